// ===== rtl/core/drum_pattern_tokenizer_macros.svh =====
`ifndef DRUM_PATTERN_TOKENIZER_MACROS_SVH
`define DRUM_PATTERN_TOKENIZER_MACROS_SVH

// condition holds on every cycle out of reset
`define DPT_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("dpt invariant violated");

// consequent holds in the same cycle as the antecedent
`define DPT_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dpt same-cycle implication violated");

// consequent holds in the cycle after the antecedent
`define DPT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dpt next-cycle implication violated");

`endif

// ===== rtl/core/dpt_pkg.sv =====
package dpt_pkg;

    localparam int LINE_WIDTH_DEF    = 16;
    localparam int COLUMN_WIDTH_DEF  = 16;
    localparam int NUMBER_WIDTH_DEF  = 32;
    localparam int KEYWORD_COUNT_DEF = 14;

    localparam int LINE_OUT_W   = 16;
    localparam int COLUMN_OUT_W = 16;
    localparam int LENGTH_W     = 16;
    localparam int NUMBER_OUT_W = 32;
    localparam int KIND_W       = 5;
    localparam int CH_W         = 8;
    localparam int TDATA_OUT_W  = 88;

    localparam int MAX_RESULTS  = 3;
    localparam int QUEUE_DEPTH  = 4;
    localparam int RES_CNT_W    = 2;

    localparam logic [KIND_W-1:0] KIND_LBRACE   = 5'd0;
    localparam logic [KIND_W-1:0] KIND_RBRACE   = 5'd1;
    localparam logic [KIND_W-1:0] KIND_LBRACKET = 5'd2;
    localparam logic [KIND_W-1:0] KIND_RBRACKET = 5'd3;
    localparam logic [KIND_W-1:0] KIND_COLON    = 5'd4;
    localparam logic [KIND_W-1:0] KIND_SEMI     = 5'd5;
    localparam logic [KIND_W-1:0] KIND_STRING   = 5'd6;
    localparam logic [KIND_W-1:0] KIND_NUMBER   = 5'd7;
    localparam logic [KIND_W-1:0] KIND_IDENT    = 5'd8;
    localparam logic [KIND_W-1:0] KIND_KW0      = 5'd9;
    localparam logic [KIND_W-1:0] KIND_EOF      = 5'd23;
    localparam logic [KIND_W-1:0] KIND_ERROR    = 5'd24;

    localparam logic [CH_W-1:0] CH_TAB      = 8'h09;
    localparam logic [CH_W-1:0] CH_LF       = 8'h0A;
    localparam logic [CH_W-1:0] CH_CR       = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [CH_W-1:0] CH_QUOTE    = 8'h22;
    localparam logic [CH_W-1:0] CH_SLASH    = 8'h2F;
    localparam logic [CH_W-1:0] CH_0        = 8'h30;
    localparam logic [CH_W-1:0] CH_9        = 8'h39;
    localparam logic [CH_W-1:0] CH_COLON    = 8'h3A;
    localparam logic [CH_W-1:0] CH_SEMI     = 8'h3B;
    localparam logic [CH_W-1:0] CH_UPPER_A  = 8'h41;
    localparam logic [CH_W-1:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [CH_W-1:0] CH_LBRACKET = 8'h5B;
    localparam logic [CH_W-1:0] CH_RBRACKET = 8'h5D;
    localparam logic [CH_W-1:0] CH_UNDER    = 8'h5F;
    localparam logic [CH_W-1:0] CH_LOWER_A  = 8'h61;
    localparam logic [CH_W-1:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [CH_W-1:0] CH_LBRACE   = 8'h7B;
    localparam logic [CH_W-1:0] CH_RBRACE   = 8'h7D;

    localparam int KW_TOTAL   = 14;
    localparam int KW_MAX_LEN = 9;
    localparam int KW_TEXT_W  = 8 * KW_MAX_LEN;

    localparam logic [KW_TEXT_W-1:0] KW_STR [KW_TOTAL] = '{
        "tempo", "pattern", "play", "song", "kick", "snare", {"snare_", "rim"},
        "Hi_Hat", "tom1", "tom2", "floor", "crash", {"ride_", "bell"}, {"ride_", "edge"}
    };
    localparam logic [3:0] KW_LEN [KW_TOTAL] = '{
        4'd5, 4'd7, 4'd4, 4'd4, 4'd4, 4'd5, 4'd9, 4'd6, 4'd4, 4'd4, 4'd5, 4'd5, 4'd9, 4'd9
    };

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_STRING,
        MODE_NUMBER,
        MODE_IDENT,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_ERROR
    } scan_mode_t;

    typedef struct packed {
        logic                    run_end;
        logic                    overflow;
        logic [NUMBER_OUT_W-1:0] value;
        logic [LENGTH_W-1:0]     length;
        logic [COLUMN_OUT_W-1:0] column;
        logic [LINE_OUT_W-1:0]   line;
        logic [KIND_W-1:0]       kind;
    } tok_t;

    typedef struct packed {
        tok_t [MAX_RESULTS-1:0] tok;
        logic [RES_CNT_W-1:0]   count;
    } tok_bundle_t;

    function automatic tok_t make_tok(
        input logic [KIND_W-1:0]       kind,
        input logic [LINE_OUT_W-1:0]   line,
        input logic [COLUMN_OUT_W-1:0] column,
        input logic [LENGTH_W-1:0]     length,
        input logic [NUMBER_OUT_W-1:0] value,
        input logic                    overflow
    );
        tok_t t;
        t.run_end  = 1'b0;
        t.overflow = overflow;
        t.value    = value;
        t.length   = length;
        t.column   = column;
        t.line     = line;
        t.kind     = kind;
        return t;
    endfunction

    // character i of keyword k, zero past its end
    function automatic logic [CH_W-1:0] kw_char(input logic [3:0] k, input logic [3:0] i);
        logic [KW_TEXT_W-1:0] s;
        s = KW_STR[k] << (8 * (KW_MAX_LEN - int'(KW_LEN[k])));
        s = s << (8 * int'(i));
        return s[KW_TEXT_W-1 -: CH_W];
    endfunction

endpackage

// ===== rtl/core/dpt_scan.sv =====
`include "drum_pattern_tokenizer_macros.svh"

module dpt_scan
    import dpt_pkg::*;
#(
    parameter int LINE_WIDTH    = LINE_WIDTH_DEF,
    parameter int COLUMN_WIDTH  = COLUMN_WIDTH_DEF,
    parameter int NUMBER_WIDTH  = NUMBER_WIDTH_DEF,
    parameter int KEYWORD_COUNT = KEYWORD_COUNT_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  logic [CH_W-1:0] in_ch,
    input  logic            in_last,
    output tok_bundle_t     bundle
);

    localparam logic [LINE_WIDTH-1:0]   LINE_ONE = LINE_WIDTH'(1);
    localparam logic [COLUMN_WIDTH-1:0] COL_ONE  = COLUMN_WIDTH'(1);
    localparam logic [LENGTH_W-1:0]     LEN_ONE  = LENGTH_W'(1);

    scan_mode_t                 mode_reg, mode_next;
    logic [LINE_WIDTH-1:0]      line_reg, line_next;
    logic [COLUMN_WIDTH-1:0]    col_reg, col_next;
    logic [COLUMN_WIDTH-1:0]    start_reg, start_next;
    logic [LENGTH_W-1:0]        len_reg, len_next;
    logic [NUMBER_WIDTH-1:0]    acc_reg, acc_next;
    logic [KEYWORD_COUNT-1:0]   kw_reg, kw_next;
    logic                       sat_reg, sat_next;

    logic                       is_digit, is_alpha, is_word, is_space;
    logic                       is_punct;
    logic [KIND_W-1:0]          punct_kind;
    logic [3:0]                 digit_val;
    logic [NUMBER_WIDTH+3:0]    mac_wide;
    logic                       mac_ovf;
    logic [LENGTH_W-1:0]        kw_pos;
    logic [KEYWORD_COUNT-1:0]   kw_keep;
    tok_t [MAX_RESULTS-1:0]     res;
    logic [RES_CNT_W-1:0]       res_n;

    function automatic logic [KIND_W-1:0] word_kind(
        input logic [KEYWORD_COUNT-1:0] alive,
        input logic [LENGTH_W-1:0]      len
    );
        logic [KIND_W-1:0] kind;
        kind = KIND_IDENT;
        for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
            if (alive[k] && len == LENGTH_W'(KW_LEN[k])) begin
                kind = KIND_KW0 + KIND_W'(k);
            end
        end
        return kind;
    endfunction

    assign is_digit  = (in_ch >= CH_0) && (in_ch <= CH_9);
    assign is_alpha  = ((in_ch >= CH_LOWER_A) && (in_ch <= CH_LOWER_Z)) ||
                       ((in_ch >= CH_UPPER_A) && (in_ch <= CH_UPPER_Z));
    assign is_word   = is_alpha || is_digit || (in_ch == CH_UNDER);
    assign is_space  = (in_ch == CH_SPACE) || (in_ch == CH_TAB) || (in_ch == CH_CR);
    assign digit_val = in_ch[3:0];

    always_comb begin
        is_punct   = 1'b1;
        punct_kind = KIND_LBRACE;
        unique case (in_ch)
            CH_LBRACE:   punct_kind = KIND_LBRACE;
            CH_RBRACE:   punct_kind = KIND_RBRACE;
            CH_LBRACKET: punct_kind = KIND_LBRACKET;
            CH_RBRACKET: punct_kind = KIND_RBRACKET;
            CH_COLON:    punct_kind = KIND_COLON;
            CH_SEMI:     punct_kind = KIND_SEMI;
            default:     is_punct   = 1'b0;
        endcase
    end

    // acc * 10 + digit, with the bits above the accumulator flagging overflow
    assign mac_wide = {3'b000, acc_reg, 1'b0} + {1'b0, acc_reg, 3'b000} +
                      {NUMBER_WIDTH'(0), digit_val};
    assign mac_ovf  = |mac_wide[NUMBER_WIDTH+3:NUMBER_WIDTH];

    assign kw_pos = (mode_reg == MODE_IDENT) ? len_reg : '0;

    always_comb begin
        for (int k = 0; k < KEYWORD_COUNT; k++) begin
            kw_keep[k] = (kw_pos < LENGTH_W'(KW_LEN[k])) &&
                         (kw_char(4'(k), kw_pos[3:0]) == in_ch);
        end
    end

    always_comb begin
        logic used;
        mode_next  = mode_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        start_next = start_reg;
        len_next   = len_reg;
        acc_next   = acc_reg;
        kw_next    = kw_reg;
        sat_next   = sat_reg;
        res        = '0;
        res_n      = '0;
        used       = 1'b0;

        if (in_valid) begin
            if (mode_reg == MODE_ERROR) begin
                if (in_last) begin
                    mode_next  = MODE_IDLE;
                    line_next  = LINE_ONE;
                    col_next   = COL_ONE;
                    start_next = COL_ONE;
                    len_next   = '0;
                    acc_next   = '0;
                    kw_next    = '1;
                    sat_next   = 1'b0;
                end
            end else begin
                unique case (mode_reg)
                    MODE_STRING: begin
                        if (in_ch == CH_QUOTE) begin
                            if (~&col_next) col_next = col_next + COL_ONE;
                            res[res_n] = make_tok(KIND_STRING, LINE_OUT_W'(line_next),
                                COLUMN_OUT_W'(start_next), len_next, '0, sat_next);
                            res_n = res_n + 1'b1;
                            mode_next = MODE_IDLE;
                        end else begin
                            if (~&len_next) len_next = len_next + LEN_ONE;
                            else sat_next = 1'b1;
                            if (~&col_next) col_next = col_next + COL_ONE;
                        end
                        used = 1'b1;
                    end
                    MODE_COMMENT: begin
                        if (in_ch != CH_LF) begin
                            if (~&col_next) col_next = col_next + COL_ONE;
                            used = 1'b1;
                        end else begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    MODE_SLASH: begin
                        if (in_ch == CH_SLASH) begin
                            if (~&col_next) col_next = col_next + COL_ONE;
                            mode_next = MODE_COMMENT;
                        end else begin
                            res[res_n] = make_tok(KIND_ERROR, LINE_OUT_W'(line_next),
                                COLUMN_OUT_W'(start_next), LEN_ONE, '0, 1'b0);
                            res_n = res_n + 1'b1;
                            mode_next = MODE_ERROR;
                        end
                        used = 1'b1;
                    end
                    MODE_NUMBER: begin
                        if (is_digit) begin
                            if (mac_ovf) begin
                                acc_next = '1;
                                sat_next = 1'b1;
                            end else begin
                                acc_next = mac_wide[NUMBER_WIDTH-1:0];
                            end
                            if (~&len_next) len_next = len_next + LEN_ONE;
                            else sat_next = 1'b1;
                            if (~&col_next) col_next = col_next + COL_ONE;
                            used = 1'b1;
                        end else begin
                            res[res_n] = make_tok(KIND_NUMBER, LINE_OUT_W'(line_next),
                                COLUMN_OUT_W'(start_next), len_next,
                                NUMBER_OUT_W'(acc_next), sat_next);
                            res_n = res_n + 1'b1;
                            mode_next = MODE_IDLE;
                        end
                    end
                    MODE_IDENT: begin
                        if (is_word) begin
                            kw_next = kw_next & kw_keep;
                            if (~&len_next) len_next = len_next + LEN_ONE;
                            else sat_next = 1'b1;
                            if (~&col_next) col_next = col_next + COL_ONE;
                            used = 1'b1;
                        end else begin
                            res[res_n] = make_tok(word_kind(kw_next, len_next),
                                LINE_OUT_W'(line_next), COLUMN_OUT_W'(start_next),
                                len_next, '0, sat_next);
                            res_n = res_n + 1'b1;
                            mode_next = MODE_IDLE;
                        end
                    end
                    default: begin
                        mode_next = MODE_IDLE;
                    end
                endcase

                if (!used && mode_next == MODE_IDLE) begin
                    if (is_space) begin
                        if (~&col_next) col_next = col_next + COL_ONE;
                    end else if (in_ch == CH_LF) begin
                        if (~&line_next) line_next = line_next + LINE_ONE;
                        col_next = COL_ONE;
                    end else if (in_ch == CH_SLASH) begin
                        start_next = col_next;
                        len_next   = '0;
                        acc_next   = '0;
                        kw_next    = '1;
                        sat_next   = 1'b0;
                        if (~&col_next) col_next = col_next + COL_ONE;
                        mode_next = MODE_SLASH;
                    end else if (is_punct) begin
                        res[res_n] = make_tok(punct_kind, LINE_OUT_W'(line_next),
                            COLUMN_OUT_W'(col_next), LEN_ONE, '0, 1'b0);
                        res_n = res_n + 1'b1;
                        if (~&col_next) col_next = col_next + COL_ONE;
                    end else if (in_ch == CH_QUOTE) begin
                        start_next = col_next;
                        len_next   = '0;
                        acc_next   = '0;
                        kw_next    = '1;
                        sat_next   = 1'b0;
                        if (~&col_next) col_next = col_next + COL_ONE;
                        mode_next = MODE_STRING;
                    end else if (is_digit) begin
                        start_next = col_next;
                        len_next   = LEN_ONE;
                        acc_next   = NUMBER_WIDTH'(digit_val);
                        kw_next    = '1;
                        sat_next   = 1'b0;
                        if (~&col_next) col_next = col_next + COL_ONE;
                        mode_next = MODE_NUMBER;
                    end else if (is_word) begin
                        start_next = col_next;
                        len_next   = LEN_ONE;
                        acc_next   = '0;
                        kw_next    = kw_keep;
                        sat_next   = 1'b0;
                        if (~&col_next) col_next = col_next + COL_ONE;
                        mode_next = MODE_IDENT;
                    end else begin
                        res[res_n] = make_tok(KIND_ERROR, LINE_OUT_W'(line_next),
                            COLUMN_OUT_W'(col_next), LEN_ONE, '0, 1'b0);
                        res_n = res_n + 1'b1;
                        if (~&col_next) col_next = col_next + COL_ONE;
                        mode_next = MODE_ERROR;
                    end
                end

                if (in_last) begin
                    case (mode_next)
                        MODE_STRING: begin
                            res[res_n] = make_tok(KIND_STRING, LINE_OUT_W'(line_next),
                                COLUMN_OUT_W'(start_next), len_next, '0, sat_next);
                            res_n = res_n + 1'b1;
                        end
                        MODE_NUMBER: begin
                            res[res_n] = make_tok(KIND_NUMBER, LINE_OUT_W'(line_next),
                                COLUMN_OUT_W'(start_next), len_next,
                                NUMBER_OUT_W'(acc_next), sat_next);
                            res_n = res_n + 1'b1;
                        end
                        MODE_IDENT: begin
                            res[res_n] = make_tok(word_kind(kw_next, len_next),
                                LINE_OUT_W'(line_next), COLUMN_OUT_W'(start_next),
                                len_next, '0, sat_next);
                            res_n = res_n + 1'b1;
                        end
                        MODE_SLASH: begin
                            res[res_n] = make_tok(KIND_ERROR, LINE_OUT_W'(line_next),
                                COLUMN_OUT_W'(start_next), LEN_ONE, '0, 1'b0);
                            res_n = res_n + 1'b1;
                            mode_next = MODE_ERROR;
                        end
                        default: begin
                        end
                    endcase
                    if (mode_next != MODE_ERROR) begin
                        res[res_n] = make_tok(KIND_EOF, LINE_OUT_W'(line_next),
                            COLUMN_OUT_W'(col_next), '0, '0, 1'b0);
                        res_n = res_n + 1'b1;
                    end
                    mode_next  = MODE_IDLE;
                    line_next  = LINE_ONE;
                    col_next   = COL_ONE;
                    start_next = COL_ONE;
                    len_next   = '0;
                    acc_next   = '0;
                    kw_next    = '1;
                    sat_next   = 1'b0;
                end
            end
        end

        for (int i = 0; i < MAX_RESULTS; i++) begin
            res[i].run_end = (res_n == RES_CNT_W'(i + 1));
        end
        bundle.tok   = res;
        bundle.count = res_n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
        end else begin
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg  <= LINE_ONE;
            col_reg   <= COL_ONE;
            start_reg <= COL_ONE;
            len_reg   <= '0;
            acc_reg   <= '0;
            kw_reg    <= '1;
            sat_reg   <= 1'b0;
        end else begin
            line_reg  <= line_next;
            col_reg   <= col_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            acc_reg   <= acc_next;
            kw_reg    <= kw_next;
            sat_reg   <= sat_next;
        end
    end

    `DPT_ASSERT_NEXT(a_last_restarts, aclk, aresetn, in_valid && in_last,
        mode_reg == MODE_IDLE && line_reg == LINE_ONE && col_reg == COL_ONE)
    `DPT_ASSERT_IMPLY(a_error_drops, aclk, aresetn, in_valid && mode_reg == MODE_ERROR,
        bundle.count == 2'd0)
    `DPT_ASSERT_IMPLY(a_last_reports, aclk, aresetn,
        in_valid && in_last && mode_reg != MODE_ERROR, bundle.count != 2'd0)

endmodule

// ===== rtl/core/dpt_queue.sv =====
`include "drum_pattern_tokenizer_macros.svh"

module dpt_queue
    import dpt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  tok_bundle_t push,
    output logic        in_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output tok_t        head
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tok_t               slot_reg  [QUEUE_DEPTH];
    tok_t               slot_next [QUEUE_DEPTH];
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;
    logic [CNT_W-1:0]   base;

    assign m_valid  = (count_reg != '0);
    assign head     = slot_reg[0];
    assign in_ready = (count_reg <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS));
    assign pop      = m_valid && m_ready;
    assign base     = count_reg - CNT_W'(pop);

    // shift down on a pop, then append new words behind the survivors
    always_comb begin
        logic [CNT_W-1:0] off;
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            if (pop && (j + 1 < QUEUE_DEPTH)) begin
                slot_next[j] = slot_reg[(j + 1) % QUEUE_DEPTH];
            end else begin
                slot_next[j] = slot_reg[j];
            end
            off = CNT_W'(j) - base;
            if ((CNT_W'(j) >= base) && (off < CNT_W'(push.count))) begin
                slot_next[j] = push.tok[off[RES_CNT_W-1:0]];
            end
        end
        count_next = base + CNT_W'(push.count);
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            slot_reg[j] <= slot_next[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    `DPT_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(QUEUE_DEPTH))
    `DPT_ASSERT_NEXT(a_push_lands, aclk, aresetn, push.count != 2'd0, count_reg != '0)
    `DPT_ASSERT_NEXT(a_pop_drains, aclk, aresetn, pop && push.count == 2'd0,
        count_reg == $past(count_reg) - 1'b1)

endmodule

// ===== rtl/core/drum_pattern_tokenizer.sv =====
// Streaming lexer for the drum-pattern language: one source byte per cycle on the slave
// side while ready; tokens leave the master side from a registered output queue. Each
// byte is decoded by a single stage of logic against the scan state and may yield zero to
// three tokens (a pending token, a punctuation mark or error, and end of text on the last
// byte); these go into a four-word output queue. The slave side is ready while at most one
// word waits in that queue, so a steady stream keeps one byte per cycle with the master
// side ready, and a byte that yields two or three tokens holds off input until the queue
// drains back to one word. After an error token, bytes are dropped through the tlast byte;
// a tlast byte not dropped that yields no error ends with an end-of-text token, and every
// tlast byte restarts line and column at one; m_axis_tlast marks a byte's last token.
module drum_pattern_tokenizer
    import dpt_pkg::*;
#(
    parameter int LINE_WIDTH    = LINE_WIDTH_DEF,
    parameter int COLUMN_WIDTH  = COLUMN_WIDTH_DEF,
    parameter int NUMBER_WIDTH  = NUMBER_WIDTH_DEF,
    parameter int KEYWORD_COUNT = KEYWORD_COUNT_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [CH_W-1:0]        s_axis_tdata,  // ch[7:0]
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // kind[4:0], line[20:5], column[36:21], length[52:37], number_value[84:53],
    // overflow[85], zero fill[87:86]
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast
);

    logic        in_ready;
    logic        in_valid;
    tok_bundle_t bundle;
    tok_t        head;

    assign s_axis_tready = in_ready;
    assign in_valid      = s_axis_tvalid && in_ready;

    dpt_scan #(
        .LINE_WIDTH    (LINE_WIDTH),
        .COLUMN_WIDTH  (COLUMN_WIDTH),
        .NUMBER_WIDTH  (NUMBER_WIDTH),
        .KEYWORD_COUNT (KEYWORD_COUNT)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid),
        .in_ch    (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .bundle   (bundle)
    );

    dpt_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (bundle),
        .in_ready (in_ready),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .head     (head)
    );

    assign m_axis_tdata = {2'b00, head.overflow, head.value, head.length,
                           head.column, head.line, head.kind};
    assign m_axis_tlast = head.run_end;

endmodule

// ===== verif/drum_pattern_tokenizer_tb.sv =====
`timescale 1ns / 100ps

module drum_pattern_tokenizer_tb
    import dpt_pkg::*;
();

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;

    localparam logic [7:0] PUNCT_CH [6] = '{CH_LBRACE, CH_RBRACE, CH_LBRACKET,
                                            CH_RBRACKET, CH_COLON, CH_SEMI};
    localparam logic [7:0] BLANK_CH [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

    class token_scoreboard;
        localparam int KEYWORDS = 14;

        string kw_names[KEYWORDS] = '{"tempo", "pattern", "play", "song", "kick",
            "snare", "snare_", "Hi_Hat", "tom1", "tom2", "floor", "crash",
            "ride_", "ride_"};

        tok_t        pending_tokens[$];
        tok_t        batch[$];
        int          errors;
        scan_mode_t  mode;
        logic [15:0] line_no;
        logic [15:0] col_no;
        logic [15:0] tok_col;
        logic [15:0] tok_len;
        logic [31:0] value_acc;
        logic [13:0] kw_alive;
        logic        sat;

        function new();
            errors = 0;
            kw_names[6]  = {kw_names[6], "rim"};
            kw_names[12] = {kw_names[12], "bell"};
            kw_names[13] = {kw_names[13], "edge"};
            restart();
        endfunction

        static function bit is_digit(logic [7:0] c);
            return c >= CH_0 && c <= CH_9;
        endfunction

        static function bit is_word_start(logic [7:0] c);
            return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
                   (c >= CH_UPPER_A && c <= CH_UPPER_Z) || c == CH_UNDER;
        endfunction

        static function int punct_code(logic [7:0] c);
            case (c)
                CH_LBRACE:   return int'(KIND_LBRACE);
                CH_RBRACE:   return int'(KIND_RBRACE);
                CH_LBRACKET: return int'(KIND_LBRACKET);
                CH_RBRACKET: return int'(KIND_RBRACKET);
                CH_COLON:    return int'(KIND_COLON);
                CH_SEMI:     return int'(KIND_SEMI);
                default:     return -1;
            endcase
        endfunction

        function void restart();
            mode      = MODE_IDLE;
            line_no   = 16'd1;
            col_no    = 16'd1;
            tok_col   = 16'd1;
            tok_len   = '0;
            value_acc = '0;
            kw_alive  = '1;
            sat       = 1'b0;
        endfunction

        function void begin_token();
            tok_col   = col_no;
            tok_len   = '0;
            value_acc = '0;
            kw_alive  = '1;
            sat       = 1'b0;
        endfunction

        function void col_step();
            if (col_no != '1) col_no++;
        endfunction

        function void len_step();
            if (tok_len != '1) tok_len++;
            else sat = 1'b1;
        endfunction

        function void add_digit(logic [7:0] c);
            logic [35:0] acc;
            acc = 36'(value_acc) * 36'd10 + 36'(c - CH_0);
            if (acc > 36'hFFFF_FFFF) begin
                value_acc = '1;
                sat = 1'b1;
            end else begin
                value_acc = acc[31:0];
            end
        endfunction

        function void kw_filter(logic [7:0] c);
            for (int k = 0; k < KEYWORDS; k++) begin
                if (int'(tok_len) >= kw_names[k].len() ||
                    8'(kw_names[k][int'(tok_len)]) != c) begin
                    kw_alive[k] = 1'b0;
                end
            end
        endfunction

        function void put_tok(logic [4:0] kind, logic [15:0] col, logic [15:0] len,
                              logic [31:0] val, logic ovf);
            tok_t t;
            if (batch.size() >= MAX_RESULTS) return;
            t.run_end  = 1'b0;
            t.overflow = ovf;
            t.value    = val;
            t.length   = len;
            t.column   = col;
            t.line     = line_no;
            t.kind     = kind;
            batch.insert(batch.size(), t);
        endfunction

        function void put_word();
            logic [4:0] kind;
            kind = KIND_IDENT;
            for (int k = KEYWORDS - 1; k >= 0; k--) begin
                if (kw_alive[k] && int'(tok_len) == kw_names[k].len()) begin
                    kind = KIND_KW0 + 5'(k);
                end
            end
            put_tok(kind, tok_col, tok_len, '0, sat);
        endfunction

        function void lex_char(logic [7:0] c, logic fin);
            bit   consumed;
            int   pk;
            tok_t t;
            batch.delete();
            if (mode == MODE_ERROR) begin
                if (fin) restart();
                return;
            end
            consumed = 1'b0;
            case (mode)
                MODE_STRING: begin
                    if (c == CH_QUOTE) begin
                        col_step();
                        put_tok(KIND_STRING, tok_col, tok_len, '0, sat);
                        mode = MODE_IDLE;
                    end else begin
                        len_step();
                        col_step();
                    end
                    consumed = 1'b1;
                end
                MODE_COMMENT: begin
                    if (c != CH_LF) begin
                        col_step();
                        consumed = 1'b1;
                    end else begin
                        mode = MODE_IDLE;
                    end
                end
                MODE_SLASH: begin
                    if (c == CH_SLASH) begin
                        col_step();
                        mode = MODE_COMMENT;
                    end else begin
                        put_tok(KIND_ERROR, tok_col, 16'd1, '0, 1'b0);
                        mode = MODE_ERROR;
                    end
                    consumed = 1'b1;
                end
                MODE_NUMBER: begin
                    if (is_digit(c)) begin
                        add_digit(c);
                        len_step();
                        col_step();
                        consumed = 1'b1;
                    end else begin
                        put_tok(KIND_NUMBER, tok_col, tok_len, value_acc, sat);
                        mode = MODE_IDLE;
                    end
                end
                MODE_IDENT: begin
                    if (is_word_start(c) || is_digit(c)) begin
                        kw_filter(c);
                        len_step();
                        col_step();
                        consumed = 1'b1;
                    end else begin
                        put_word();
                        mode = MODE_IDLE;
                    end
                end
                default: mode = MODE_IDLE;
            endcase

            if (!consumed && mode == MODE_IDLE) begin
                pk = punct_code(c);
                if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
                    col_step();
                end else if (c == CH_LF) begin
                    if (line_no != '1) line_no++;
                    col_no = 16'd1;
                end else if (c == CH_SLASH) begin
                    begin_token();
                    col_step();
                    mode = MODE_SLASH;
                end else if (pk >= 0) begin
                    put_tok(5'(pk), col_no, 16'd1, '0, 1'b0);
                    col_step();
                end else if (c == CH_QUOTE) begin
                    begin_token();
                    col_step();
                    mode = MODE_STRING;
                end else if (is_digit(c)) begin
                    begin_token();
                    add_digit(c);
                    len_step();
                    col_step();
                    mode = MODE_NUMBER;
                end else if (is_word_start(c)) begin
                    begin_token();
                    kw_filter(c);
                    len_step();
                    col_step();
                    mode = MODE_IDENT;
                end else begin
                    put_tok(KIND_ERROR, col_no, 16'd1, '0, 1'b0);
                    col_step();
                    mode = MODE_ERROR;
                end
            end

            if (fin) begin
                case (mode)
                    MODE_STRING: put_tok(KIND_STRING, tok_col, tok_len, '0, sat);
                    MODE_NUMBER: put_tok(KIND_NUMBER, tok_col, tok_len, value_acc, sat);
                    MODE_IDENT:  put_word();
                    MODE_SLASH: begin
                        put_tok(KIND_ERROR, tok_col, 16'd1, '0, 1'b0);
                        mode = MODE_ERROR;
                    end
                    default: ;
                endcase
                if (mode != MODE_ERROR) put_tok(KIND_EOF, col_no, '0, '0, 1'b0);
                restart();
            end

            foreach (batch[i]) begin
                t = batch[i];
                t.run_end = (i == batch.size() - 1);
                pending_tokens.insert(pending_tokens.size(), t);
            end
        endfunction

        function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name,
                         exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_token(logic [TDATA_OUT_W-1:0] data, logic last);
            tok_t e;
            if (pending_tokens.size() == 0) begin
                $display("%0t: unexpected token: expected none, actual %h last %b",
                         $time, data, last);
                errors++;
                return;
            end
            e = pending_tokens.pop_front();
            check_field("kind", 32'(e.kind), 32'(data[4:0]));
            check_field("line", 32'(e.line), 32'(data[20:5]));
            check_field("column", 32'(e.column), 32'(data[36:21]));
            check_field("length", 32'(e.length), 32'(data[52:37]));
            check_field("number_value", e.value, data[84:53]);
            check_field("overflow", 32'(e.overflow), 32'(data[85]));
            check_field("run_end", 32'(e.run_end), 32'(last));
        endfunction
    endclass

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [CH_W-1:0]        s_axis_tdata  = '0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    token_scoreboard sb = new();

    logic [7:0] src_text[$];
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int cycle_count    = 0;

    drum_pattern_tokenizer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            sb.lex_char(s_axis_tdata, s_axis_tlast);
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.check_token(m_axis_tdata, m_axis_tlast);
        end
    end

    function automatic void put_byte(logic [7:0] c);
        src_text.insert(src_text.size(), c);
    endfunction

    function automatic void append_str(string s);
        for (int i = 0; i < s.len(); i++) put_byte(8'(s[i]));
    endfunction

    function automatic logic [7:0] any_but(logic [7:0] x);
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == x);
        return c;
    endfunction

    function automatic logic [7:0] word_char();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
            1:       return 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
            2:       return 8'($urandom_range(CH_0, CH_9));
            default: return CH_UNDER;
        endcase
    endfunction

    function automatic logic [7:0] odd_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (token_scoreboard::is_word_start(c) || token_scoreboard::is_digit(c) ||
               token_scoreboard::punct_code(c) >= 0 ||
               c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_SLASH, CH_QUOTE});
        return c;
    endfunction

    // mostly well-formed token sequences; rare unknown bytes and lone slashes
    function automatic void compose_text();
        int n;
        int len;
        src_text.delete();
        n = $urandom_range(2, 10);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: put_byte(PUNCT_CH[$urandom_range(0, 5)]);
                1, 2: begin
                    append_str(sb.kw_names[$urandom_range(0, 13)]);
                    case ($urandom_range(0, 5))
                        0:       put_byte(word_char());
                        1:       void'(src_text.pop_back());
                        default: ;
                    endcase
                end
                3: begin
                    if ($urandom_range(0, 4) == 0) put_byte(CH_UNDER);
                    else if ($urandom_range(0, 1) != 0)
                        put_byte(8'($urandom_range(CH_LOWER_A, CH_LOWER_Z)));
                    else put_byte(8'($urandom_range(CH_UPPER_A, CH_UPPER_Z)));
                    len = $urandom_range(0, 7);
                    repeat (len) put_byte(word_char());
                end
                4: begin
                    len = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 13)
                                                       : $urandom_range(1, 4);
                    repeat (len) put_byte(8'($urandom_range(CH_0, CH_9)));
                end
                5: begin
                    put_byte(CH_QUOTE);
                    len = $urandom_range(0, 6);
                    repeat (len) put_byte(any_but(CH_QUOTE));
                    if (i < n - 1 || $urandom_range(0, 3) != 0) put_byte(CH_QUOTE);
                end
                6: begin
                    put_byte(CH_SLASH);
                    put_byte(CH_SLASH);
                    len = $urandom_range(0, 6);
                    repeat (len) put_byte(any_but(CH_LF));
                    put_byte(CH_LF);
                end
                7: begin
                    if ($urandom_range(0, 5) != 0)
                        put_byte(BLANK_CH[$urandom_range(0, 3)]);
                    else if ($urandom_range(0, 1) != 0) put_byte(CH_SLASH);
                    else put_byte(odd_byte());
                end
                default: put_byte(BLANK_CH[$urandom_range(0, 3)]);
            endcase
            case ($urandom_range(0, 3))
                0:       put_byte(CH_SPACE);
                1:       put_byte(CH_LF);
                default: ;
            endcase
        end
    endfunction

    task automatic send_text();
        for (int i = 0; i < src_text.size(); i++) begin
            while ($urandom_range(0, 99) < send_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= src_text[i];
            s_axis_tlast  <= (i == src_text.size() - 1);
            @(posedge aclk);
            while (!s_axis_tready) @(posedge aclk);
        end
    endtask

    task automatic send_str(string s);
        src_text.delete();
        append_str(s);
        send_text();
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int n_chars);
        int sent;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_chars) begin
            compose_text();
            send_text();
            sent += src_text.size();
        end
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("drum_pattern_tokenizer_tb failed");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_str("{}[]:;");
        send_str("\"q\"42x");
        send_str("/x");
        send_str("/");
        src_text.delete();
        append_str("//\n");
        put_byte(8'hFF);
        send_text();
        send_str("\"ab");
        send_str("$x");

        hold_requests++;
        run_phase(0, 0, 75);
        run_phase(47, 0, 75);
        run_phase(0, 47, 75);
        run_phase(37, 37, 75);
        s_axis_tvalid <= 1'b0;

        while (sb.pending_tokens.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("drum_pattern_tokenizer_tb passed");
        end else begin
            $display("drum_pattern_tokenizer_tb failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/dpt_pkg.sv
rtl/core/dpt_scan.sv
rtl/core/dpt_queue.sv
rtl/core/drum_pattern_tokenizer.sv
verif/drum_pattern_tokenizer_tb.sv
